### hdl/tcwe_pkg.sv
// ----------------------------------------------------------------------------
// tcwe_pkg
// Shared types, constants and the colour table for the throttle conditioner.
// ----------------------------------------------------------------------------
package tcwe_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_DEAD_LOW    = 3'd0;
    localparam logic [2:0] REG_DEAD_HIGH   = 3'd1;
    localparam logic [2:0] REG_SPEED_MIN   = 3'd2;
    localparam logic [2:0] REG_CHANGE_STEP = 3'd3;
    localparam logic [2:0] REG_DEBOUNCE_MS = 3'd4;

    // Configuration reset values
    localparam logic [11:0] DEAD_LOW_RST    = 12'd1800;
    localparam logic [11:0] DEAD_HIGH_RST   = 12'd2300;
    localparam logic [6:0]  SPEED_MIN_RST   = 7'd20;
    localparam logic [7:0]  CHANGE_STEP_RST = 8'd5;
    localparam logic [15:0] DEBOUNCE_MS_RST = 16'd200;

    // Command kinds
    localparam logic [1:0] KIND_MOTOR = 2'd0;
    localparam logic [1:0] KIND_LED   = 2'd1;
    localparam logic [1:0] KIND_HORN  = 2'd2;

    // Filter: Q12.16 state, weight 9830/65536 on the new sample
    localparam int          SMOOTH_W   = 28;
    localparam logic [15:0] FILT_NEW   = 16'd9830;
    localparam logic [15:0] FILT_KEEP  = 16'd55706;
    localparam logic [27:0] SMOOTH_RST = 28'h8000000;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Divider widths: d*d*(100-sm) over R*R
    localparam int DIV_NUM_W = 31;
    localparam int DIV_DEN_W = 24;

    localparam logic [11:0] ADC_MAX   = 12'd4095;
    localparam logic [6:0]  SPEED_MAX = 7'd100;

    localparam int COLOR_COUNT_DEF = 11;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] speed;
        logic [3:0] color;
    } cmd_t;

    function automatic logic [3:0] color_lookup(input logic [3:0] pos);
        logic [3:0] code;
        begin
            case (pos)
                4'd0:    code = 4'h0;
                4'd1:    code = 4'h1;
                4'd2:    code = 4'h7;
                4'd3:    code = 4'h8;
                4'd4:    code = 4'h9;
                4'd5:    code = 4'hf;
                4'd6:    code = 4'ha;
                4'd7:    code = 4'he;
                4'd8:    code = 4'hb;
                4'd9:    code = 4'hd;
                4'd10:   code = 4'hc;
                default: code = 4'h0;
            endcase
            return code;
        end
    endfunction

endpackage

### hdl/tcwe_mul.sv
// ----------------------------------------------------------------------------
// tcwe_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tcwe_mul (
    input  logic                          clk,
    input  logic [tcwe_pkg::MUL_A_W-1:0]  op_a,
    input  logic [tcwe_pkg::MUL_B_W-1:0]  op_b,
    output logic [tcwe_pkg::MUL_P_W-1:0]  prod
);

    logic [tcwe_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= tcwe_pkg::MUL_P_W'(op_a) * tcwe_pkg::MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

### hdl/tcwe_div.sv
// ----------------------------------------------------------------------------
// tcwe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcwe_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tcwe_pkg::DIV_NUM_W-1:0]  num,
    input  logic [tcwe_pkg::DIV_DEN_W-1:0]  den,
    output logic                            done,
    output logic [tcwe_pkg::DIV_NUM_W-1:0]  quot
);

    localparam int NW  = tcwe_pkg::DIV_NUM_W;
    localparam int DW  = tcwe_pkg::DIV_DEN_W;
    localparam int CW  = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] quo_reg;

    logic [DW:0]   trial;
    logic [DW:0]   trial_sub;
    logic          fits;

    assign trial     = {rem_reg, quo_reg[NW-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### hdl/throttle_conditioner_with_estop.sv
// ----------------------------------------------------------------------------
// throttle_conditioner_with_estop
// Pot smoothing, dead-zone speed curve, button debounce and e-stop latch.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one tick: pot_sample, the two
//   active-low button levels and now_ms. Output channel (out_valid/out_stall)
//   carries zero to four command items per tick, the last flagged by
//   last_of_tick. Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   are always ready; the user must let them go in only while the block
//   is idle, as the block does not enforce it. One tick runs through a
//   small sequencer around one shared 28x16 multiplier (filter, d*d, R*R,
//   scaling) and a bit-serial divider. Steps: F1 and F2 filter; ZONE, M2
//   and M3 form d*d, R*R and the scaled product; M4 starts the divider
//   (skipped inside the dead zone or when R is zero); DIV waits on it;
//   DECIDE builds the commands; EMIT hands them out one per cycle while
//   out_stall is low. in_stall stays high from accept until the last
//   command is taken, or until DECIDE if none, so ticks do not overlap.
//   While the receiver stalls, the current command holds on the outputs.
//   Reset: filter at mid scale (2048.0), speed 0, latch clear, colour
//   position 1, buttons released, config at its defaults.
// ----------------------------------------------------------------------------
module throttle_conditioner_with_estop #(
    parameter int COLOR_COUNT = tcwe_pkg::COLOR_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] pot_sample,
    input  logic        act_button,
    input  logic        stop_button,
    input  logic [31:0] now_ms,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  cmd_kind,
    output logic signed [7:0] motor_speed,
    output logic        confirm_write,
    output logic [3:0]  color_code,
    output logic        last_of_tick,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int POS_W = $clog2(COLOR_COUNT);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_F1     = 4'd1;
    localparam logic [3:0] S_F2     = 4'd2;
    localparam logic [3:0] S_ZONE   = 4'd3;
    localparam logic [3:0] S_M2     = 4'd4;
    localparam logic [3:0] S_M3     = 4'd5;
    localparam logic [3:0] S_M4     = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DECIDE = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]  state_reg;

    // Config registers
    logic [11:0] dead_low_reg;
    logic [11:0] dead_high_reg;
    logic [6:0]  speed_min_reg;
    logic [7:0]  change_step_reg;
    logic [15:0] debounce_reg;

    // Tick state
    logic [27:0]       smoothed_reg;
    logic [7:0]        last_speed_reg;
    logic              latched_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              act_prev_reg;
    logic              stop_prev_reg;
    logic [31:0]       act_time_reg;
    logic [31:0]       stop_time_reg;

    // Captured item and intermediates
    logic [11:0] pot_reg;
    logic        act_reg;
    logic        stp_reg;
    logic [31:0] now_reg;
    logic [tcwe_pkg::MUL_P_W-1:0]   acc_reg;
    logic [tcwe_pkg::DIV_DEN_W-1:0] dd_reg;
    logic [tcwe_pkg::DIV_DEN_W-1:0] rr_reg;

    // Command buffer
    tcwe_pkg::cmd_t buf_reg [4];
    logic [2:0]     cnt_reg;
    logic [1:0]     idx_reg;

    logic in_acc;
    logic out_acc;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic [tcwe_pkg::MUL_A_W-1:0] mul_a;
    logic [tcwe_pkg::MUL_B_W-1:0] mul_b;
    logic [tcwe_pkg::MUL_P_W-1:0] mul_p;

    tcwe_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // ------------------------------------------------------------------
    // Dead zone geometry from the smoothed value
    // ------------------------------------------------------------------
    logic [11:0] pot_v;
    logic        above;
    logic        in_zone;
    logic [11:0] zone_dist;
    logic [11:0] range;
    logic [6:0]  sm_c;
    logic [6:0]  span;

    assign pot_v     = smoothed_reg[27:16];
    assign above     = (pot_v > dead_high_reg);
    assign in_zone   = (pot_v >= dead_low_reg) && (pot_v <= dead_high_reg);
    assign zone_dist = above ? (pot_v - dead_high_reg) : (dead_low_reg - pot_v);
    assign range     = above ? (tcwe_pkg::ADC_MAX - dead_high_reg) : dead_low_reg;
    assign sm_c      = (speed_min_reg > tcwe_pkg::SPEED_MAX) ? tcwe_pkg::SPEED_MAX
                                                             : speed_min_reg;
    assign span      = tcwe_pkg::SPEED_MAX - sm_c;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_IDLE:
            begin
                mul_a = smoothed_reg;
                mul_b = tcwe_pkg::FILT_KEEP;
            end
            S_F1:
            begin
                mul_a = tcwe_pkg::MUL_A_W'(pot_reg);
                mul_b = tcwe_pkg::FILT_NEW;
            end
            S_ZONE:
            begin
                mul_a = tcwe_pkg::MUL_A_W'(zone_dist);
                mul_b = tcwe_pkg::MUL_B_W'(zone_dist);
            end
            S_M2:
            begin
                mul_a = tcwe_pkg::MUL_A_W'(range);
                mul_b = tcwe_pkg::MUL_B_W'(range);
            end
            S_M3:
            begin
                mul_a = tcwe_pkg::MUL_A_W'(dd_reg);
                mul_b = tcwe_pkg::MUL_B_W'(span);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Filter sum: old*55706 + (pot*9830)<<16, keep bits [43:16]
    logic [tcwe_pkg::MUL_P_W:0] filt_sum;
    assign filt_sum = {1'b0, acc_reg} + {1'b0, mul_p[27:0], 16'b0};

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    logic                             div_start;
    logic                             div_done;
    logic [tcwe_pkg::DIV_NUM_W-1:0]   div_q;
    logic                             skip_div;

    assign skip_div  = in_zone || (range == 12'd0);
    assign div_start = (state_reg == S_M4) && !skip_div;

    tcwe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_p[tcwe_pkg::DIV_NUM_W-1:0]),
        .den   (rr_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // ------------------------------------------------------------------
    // Speed and command decisions
    // ------------------------------------------------------------------
    logic [7:0]       mag_sum;
    logic [6:0]       mag;
    logic [7:0]       cur;
    logic [8:0]       diff;
    logic [8:0]       diff_abs;
    logic             motor_send;
    logic             act_hit;
    logic             stop_hit;
    logic             stop_cmd;
    logic [POS_W-1:0] pos_inc;
    logic [31:0]      act_gap;
    logic [31:0]      stop_gap;

    tcwe_pkg::cmd_t   ent [4];
    logic [2:0]       ent_cnt;
    logic [7:0]       last_speed_next;
    logic             latched_next;
    logic [POS_W-1:0] pos_next;

    always_comb
    begin
        mag_sum = {1'b0, sm_c} + {1'b0, div_q[6:0]};
        if (range == 12'd0)
            mag = sm_c;
        else if ((div_q[tcwe_pkg::DIV_NUM_W-1:7] != '0) ||
                 (mag_sum > {1'b0, tcwe_pkg::SPEED_MAX}))
            mag = tcwe_pkg::SPEED_MAX;
        else
            mag = mag_sum[6:0];

        if (in_zone)
            cur = 8'd0;
        else if (above)
            cur = {1'b0, mag};
        else
            cur = 8'd0 - {1'b0, mag};

        diff     = {cur[7], cur} - {last_speed_reg[7], last_speed_reg};
        diff_abs = diff[8] ? (9'd0 - diff) : diff;

        motor_send = !latched_reg &&
                     ((diff_abs >= {1'b0, change_step_reg}) ||
                      ((cur == 8'd0) && (last_speed_reg != 8'd0)));

        act_gap  = now_reg - act_time_reg;
        stop_gap = now_reg - stop_time_reg;
        act_hit  = !act_reg && act_prev_reg && (act_gap > {16'b0, debounce_reg});
        stop_hit = !stp_reg && stop_prev_reg && (stop_gap > {16'b0, debounce_reg});
        stop_cmd = stop_hit && (cur != 8'd0);

        pos_inc = (pos_reg == POS_W'(COLOR_COUNT - 1)) ? '0 : (pos_reg + 1'b1);

        for (int i = 0; i < 4; i++)
            ent[i] = '0;
        ent_cnt         = 3'd0;
        last_speed_next = last_speed_reg;
        latched_next    = latched_reg;
        pos_next        = pos_reg;

        if (latched_reg)
        begin
            if (cur == 8'd0)
                latched_next = 1'b0;
        end
        else if (motor_send)
        begin
            ent[ent_cnt[1:0]].kind  = tcwe_pkg::KIND_MOTOR;
            ent[ent_cnt[1:0]].speed = cur;
            ent_cnt                 = ent_cnt + 3'd1;
            last_speed_next         = cur;
        end

        if (act_hit)
        begin
            pos_next                = pos_inc;
            ent[ent_cnt[1:0]].kind  = tcwe_pkg::KIND_LED;
            ent[ent_cnt[1:0]].color = tcwe_pkg::color_lookup(4'(pos_inc));
            ent_cnt                 = ent_cnt + 3'd1;
        end

        if (stop_hit)
        begin
            ent[ent_cnt[1:0]].kind = tcwe_pkg::KIND_HORN;
            ent_cnt                = ent_cnt + 3'd1;
        end

        if (stop_cmd)
        begin
            ent[ent_cnt[1:0]].kind = tcwe_pkg::KIND_MOTOR;
            ent_cnt                = ent_cnt + 3'd1;
            last_speed_next        = 8'd0;
            latched_next           = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Config port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_low_reg    <= tcwe_pkg::DEAD_LOW_RST;
            dead_high_reg   <= tcwe_pkg::DEAD_HIGH_RST;
            speed_min_reg   <= tcwe_pkg::SPEED_MIN_RST;
            change_step_reg <= tcwe_pkg::CHANGE_STEP_RST;
            debounce_reg    <= tcwe_pkg::DEBOUNCE_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcwe_pkg::REG_DEAD_LOW:    dead_low_reg    <= cfg_data[11:0];
                tcwe_pkg::REG_DEAD_HIGH:   dead_high_reg   <= cfg_data[11:0];
                tcwe_pkg::REG_SPEED_MIN:   speed_min_reg   <= cfg_data[6:0];
                tcwe_pkg::REG_CHANGE_STEP: change_step_reg <= cfg_data[7:0];
                tcwe_pkg::REG_DEBOUNCE_MS: debounce_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and tick state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            smoothed_reg   <= tcwe_pkg::SMOOTH_RST;
            last_speed_reg <= 8'd0;
            latched_reg    <= 1'b0;
            pos_reg        <= POS_W'(1);
            act_prev_reg   <= 1'b1;
            stop_prev_reg  <= 1'b1;
            act_time_reg   <= 32'd0;
            stop_time_reg  <= 32'd0;
            cnt_reg        <= 3'd0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                        state_reg <= S_F1;
                end
                S_F1:
                    state_reg <= S_F2;
                S_F2:
                begin
                    smoothed_reg <= filt_sum[43:16];
                    state_reg    <= S_ZONE;
                end
                S_ZONE:
                    state_reg <= S_M2;
                S_M2:
                    state_reg <= S_M3;
                S_M3:
                    state_reg <= S_M4;
                S_M4:
                    state_reg <= skip_div ? S_DECIDE : S_DIV;
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    last_speed_reg <= last_speed_next;
                    latched_reg    <= latched_next;
                    pos_reg        <= pos_next;
                    act_prev_reg   <= act_reg;
                    stop_prev_reg  <= stp_reg;
                    if (act_hit)
                        act_time_reg <= now_reg;
                    if (stop_hit)
                        stop_time_reg <= now_reg;
                    cnt_reg   <= ent_cnt;
                    idx_reg   <= 2'd0;
                    state_reg <= (ent_cnt == 3'd0) ? S_IDLE : S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_acc)
                    begin
                        if ({1'b0, idx_reg} == cnt_reg - 3'd1)
                            state_reg <= S_IDLE;
                        else
                            idx_reg <= idx_reg + 2'd1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pot_reg <= pot_sample;
            act_reg <= act_button;
            stp_reg <= stop_button;
            now_reg <= now_ms;
        end
        if (state_reg == S_F1)
            acc_reg <= mul_p;
        if (state_reg == S_M2)
            dd_reg <= mul_p[tcwe_pkg::DIV_DEN_W-1:0];
        if (state_reg == S_M3)
            rr_reg <= mul_p[tcwe_pkg::DIV_DEN_W-1:0];
        if (state_reg == S_DECIDE)
        begin
            for (int i = 0; i < 4; i++)
                buf_reg[i] <= ent[i];
        end
    end

    // ------------------------------------------------------------------
    // Output item
    // ------------------------------------------------------------------
    tcwe_pkg::cmd_t cur_cmd;
    assign cur_cmd = buf_reg[idx_reg];

    assign cmd_kind      = cur_cmd.kind;
    assign motor_speed   = $signed(cur_cmd.speed);
    assign color_code    = cur_cmd.color;
    assign confirm_write = (cur_cmd.kind == tcwe_pkg::KIND_MOTOR) &&
                           (cur_cmd.speed == 8'd0);
    assign last_of_tick  = ({1'b0, idx_reg} == cnt_reg - 3'd1);

endmodule

### sim/tb_throttle_conditioner_with_estop.sv
// ----------------------------------------------------------------------------
// tb_throttle_conditioner_with_estop
// Self-checking bench: pot filter, dead-zone speed curve, buttons and e-stop.
// Ticks are driven through the valid/stall input channel and checked command
// by command against an in-bench model of the block. Runs a directed opening,
// then random ticks under several register settings, with random idling on
// both channels.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [1:0] kind;
    logic [7:0] speed;
    logic       confirm;
    logic [3:0] color;
    logic       last;
} cmd_item_t;

class throttle_scoreboard;
    // register copies
    logic [11:0] dead_lo, dead_hi;
    logic [6:0]  min_speed;
    logic [7:0]  step_size;
    logic [15:0] debounce;

    // block state copies
    logic [27:0] smooth;
    int          last_speed;
    bit          latched;
    int          color_pos;
    logic        act_prev, stop_prev;
    logic [31:0] act_t, stop_t;
    logic [3:0]  color_tab [16];

    cmd_item_t   tick_cmds[$];
    cmd_item_t   pending_cmds[$];

    int errors, n_ticks, n_motor, n_confirm, n_led, n_horn;

    function new();
        dead_lo    = tcwe_pkg::DEAD_LOW_RST;
        dead_hi    = tcwe_pkg::DEAD_HIGH_RST;
        min_speed  = tcwe_pkg::SPEED_MIN_RST;
        step_size  = tcwe_pkg::CHANGE_STEP_RST;
        debounce   = tcwe_pkg::DEBOUNCE_MS_RST;
        smooth     = 28'd2048 << 16;
        last_speed = 0;
        latched    = 1'b0;
        color_pos  = 1;
        act_prev   = 1'b1;
        stop_prev  = 1'b1;
        act_t      = '0;
        stop_t     = '0;
        color_tab  = '{4'h0, 4'h1, 4'h7, 4'h8, 4'h9, 4'hf, 4'ha, 4'he,
                       4'hb, 4'hd, 4'hc, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0};
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            tcwe_pkg::REG_DEAD_LOW:    dead_lo   = val[11:0];
            tcwe_pkg::REG_DEAD_HIGH:   dead_hi   = val[11:0];
            tcwe_pkg::REG_SPEED_MIN:   min_speed = val[6:0];
            tcwe_pkg::REG_CHANGE_STEP: step_size = val[7:0];
            tcwe_pkg::REG_DEBOUNCE_MS: debounce  = val[15:0];
            default: ;
        endcase
    endfunction

    // Signed speed for a smoothed value: quadratic outside the dead zone.
    function int speed_for(logic [11:0] v);
        longint unsigned sm, d, r, mag;
        bit neg;
        sm = (min_speed > 7'd100) ? 100 : min_speed;
        if (v >= dead_lo && v <= dead_hi)
            return 0;
        if (v > dead_hi) begin
            d   = v - dead_hi;
            r   = 12'd4095 - dead_hi;
            neg = 1'b0;
        end
        else begin
            d   = dead_lo - v;
            r   = dead_lo;
            neg = 1'b1;
        end
        mag = sm;
        if (r != 0)
            mag += (d * d * (100 - sm)) / (r * r);
        if (mag > 100)
            mag = 100;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    function void add_cmd(logic [1:0] kind, int spd, logic [3:0] color);
        cmd_item_t c;
        c.kind    = kind;
        c.speed   = spd[7:0];
        c.confirm = (kind == tcwe_pkg::KIND_MOTOR && spd == 0);
        c.color   = color;
        c.last    = 1'b0;
        tick_cmds.push_back(c);
    endfunction

    // One accepted tick: advance the model and queue the commands it causes.
    function void note_tick(logic [11:0] pot, logic act, logic stp, logic [31:0] now);
        logic [63:0] acc;
        logic [31:0] elapsed;
        int cur, diff;
        cmd_item_t tail;
        n_ticks++;
        tick_cmds.delete();
        acc = 64'(smooth) * 64'd55706 + (64'(pot) << 16) * 64'd9830;
        smooth = acc[43:16];
        cur = speed_for(smooth[27:16]);

        if (latched) begin
            if (cur == 0)
                latched = 1'b0;
        end
        else begin
            diff = cur - last_speed;
            if (diff < 0)
                diff = -diff;
            if (diff >= int'(step_size) || (cur == 0 && last_speed != 0)) begin
                add_cmd(tcwe_pkg::KIND_MOTOR, cur, 4'h0);
                last_speed = cur;
            end
        end

        elapsed = now - act_t;
        if (!act && act_prev && elapsed > 32'(debounce)) begin
            color_pos = (color_pos + 1) % tcwe_pkg::COLOR_COUNT_DEF;
            add_cmd(tcwe_pkg::KIND_LED, 0, color_tab[color_pos]);
            act_t = now;
        end
        act_prev = act;

        elapsed = now - stop_t;
        if (!stp && stop_prev && elapsed > 32'(debounce)) begin
            add_cmd(tcwe_pkg::KIND_HORN, 0, 4'h0);
            if (cur != 0) begin
                add_cmd(tcwe_pkg::KIND_MOTOR, 0, 4'h0);
                last_speed = 0;
                latched    = 1'b1;
            end
            stop_t = now;
        end
        stop_prev = stp;

        if (tick_cmds.size() != 0) begin
            tail = tick_cmds.pop_back();
            tail.last = 1'b1;
            tick_cmds.push_back(tail);
        end
        foreach (tick_cmds[i])
            pending_cmds.push_back(tick_cmds[i]);
    endfunction

    function bit field_differs(string name, integer want, integer got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void check_cmd(cmd_item_t got);
        cmd_item_t want;
        bit bad;
        if (pending_cmds.size() == 0) begin
            errors++;
            $display("%0t: unexpected command, expected none, got kind %0d speed %0d color %0d",
                     $time, got.kind, $signed(got.speed), got.color);
            return;
        end
        want = pending_cmds.pop_front();
        bad = 1'b0;
        bad |= field_differs("cmd_kind", want.kind, got.kind);
        bad |= field_differs("motor_speed", $signed(want.speed), $signed(got.speed));
        bad |= field_differs("confirm_write", want.confirm, got.confirm);
        bad |= field_differs("color_code", want.color, got.color);
        bad |= field_differs("last_of_tick", want.last, got.last);
        if (bad)
            errors++;
        case (want.kind)
            tcwe_pkg::KIND_MOTOR: begin
                n_motor++;
                if (want.confirm)
                    n_confirm++;
            end
            tcwe_pkg::KIND_LED:  n_led++;
            tcwe_pkg::KIND_HORN: n_horn++;
            default: ;
        endcase
    endfunction
endclass

module tb_throttle_conditioner_with_estop;

    localparam int RANDOM_PER_PHASE = 80;
    localparam int PHASES           = 6;
    localparam int SETTLE_CYCLES    = 120;   // well past one tick's run through the block
    localparam int STALL_LIMIT      = 3000;  // cycles without any handshake

    logic        clk;
    logic        rst_n         = 1'b0;

    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [11:0] pot_sample    = 12'd2048;
    logic        act_button    = 1'b1;
    logic        stop_button   = 1'b1;
    logic [31:0] now_ms        = '0;

    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [1:0]  cmd_kind;
    logic signed [7:0] motor_speed;
    logic        confirm_write;
    logic [3:0]  color_code;
    logic        last_of_tick;

    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = tcwe_pkg::REG_DEAD_LOW;
    logic [15:0] cfg_data      = '0;

    throttle_scoreboard sb = new();

    logic [31:0] clock_ms;     // running timestamp fed on now_ms
    bit          steady;       // set: neither side idles
    int          idle_cycles = 0;
    int          settings_used;
    cmd_item_t   seen;

    throttle_conditioner_with_estop uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pot_sample    (pot_sample),
        .act_button    (act_button),
        .stop_button   (stop_button),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cmd_kind      (cmd_kind),
        .motor_speed   (motor_speed),
        .confirm_write (confirm_write),
        .color_code    (color_code),
        .last_of_tick  (last_of_tick),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: everything is sampled at the edge, before this edge's updates
    // land, so the model sees exactly what the block saw. The receiver stall
    // is drawn here too.
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sb.note_tick(pot_sample, act_button, stop_button, now_ms);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                sb.set_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (out_valid && !out_stall) begin
                seen.kind    = cmd_kind;
                seen.speed   = motor_speed;
                seen.confirm = confirm_write;
                seen.color   = color_code;
                seen.last    = last_of_tick;
                sb.check_cmd(seen);
                moved = 1'b1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            out_stall   <= !steady && ($urandom_range(0, 99) < 25);
        end
    end

    // Watchdog: no handshake of any kind for too long means the block hung.
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Present one tick and hold it until accepted. An optional gap in front
    // lands on whatever phase of the previous tick the block is in.
    task automatic send_tick(input logic [11:0] pot, input logic act, input logic stp,
                             input logic [31:0] ms);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 25)
            gap = $urandom_range(1, 50);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pot_sample  <= pot;
        act_button  <= act;
        stop_button <= stp;
        now_ms      <= ms;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic tick(input logic [11:0] pot, input logic act, input logic stp,
                        input logic [31:0] dt);
        clock_ms = clock_ms + dt;
        send_tick(pot, act, stp, clock_ms);
    endtask

    // Stop sending, let every queued command drain, then give ticks that
    // produced nothing time to finish inside the block.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_cmds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers back to back; valid drops only after the last.
    task automatic set_config(input logic [11:0] lo, input logic [11:0] hi,
                              input logic [6:0] sm, input logic [7:0] stp,
                              input logic [15:0] deb);
        logic [15:0] vals [5];
        logic [2:0]  idxs [5];
        int k;
        vals = '{16'(lo), 16'(hi), 16'(sm), 16'(stp), deb};
        idxs = '{tcwe_pkg::REG_DEAD_LOW, tcwe_pkg::REG_DEAD_HIGH,
                 tcwe_pkg::REG_SPEED_MIN, tcwe_pkg::REG_CHANGE_STEP,
                 tcwe_pkg::REG_DEBOUNCE_MS};
        for (k = 0; k < 5; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random ticks shaped like real use: the pot dwells on a target for a
    // while, buttons are held for a few ticks, time advances 20 to 160 ms per tick.
    // A small share is noise: pot jumps, time jumps and random button levels.
    task automatic run_random(input int count);
        int i, hold, act_hold, stop_hold, roll;
        logic [11:0] target, pot;
        logic act, stp;
        logic [31:0] dt;
        clock_ms  = $urandom();
        hold      = 0;
        act_hold  = 0;
        stop_hold = 0;
        target    = 12'd2048;
        for (i = 0; i < count; i++) begin
            if (hold == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    target = (roll < 7) ? 12'd0 : 12'd4095;
                else
                    target = 12'($urandom_range(0, 4095));
                hold = $urandom_range(2, 12);
            end
            hold--;
            pot = ($urandom_range(0, 99) < 8) ? 12'($urandom_range(0, 4095)) : target;

            act = 1'b1;
            if (act_hold > 0) begin
                act = 1'b0;
                act_hold--;
            end
            else if ($urandom_range(0, 99) < 12) begin
                act = 1'b0;
                act_hold = $urandom_range(0, 2);
            end
            stp = 1'b1;
            if (stop_hold > 0) begin
                stp = 1'b0;
                stop_hold--;
            end
            else if ($urandom_range(0, 99) < 8) begin
                stp = 1'b0;
                stop_hold = $urandom_range(0, 2);
            end

            roll = $urandom_range(0, 99);
            if (roll < 4)
                dt = $urandom();
            else
                dt = $urandom_range(20, 160);
            if (roll >= 96) begin
                act = 1'($urandom_range(0, 1));
                stp = 1'($urandom_range(0, 1));
            end
            tick(pot, act, stp, dt);
        end
    endtask

    initial
    begin
        int ph;
        steady        = 1'b0;
        settings_used = 1;          // reset defaults
        clock_ms      = 32'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset settings.
        // Both buttons at zero speed: LED and horn, but no confirmed stop.
        tick(12'd2048, 1'b0, 1'b0, 32'd1000);
        // Full throttle: speed climbs in steps of at least the change step.
        repeat (4) tick(12'd4095, 1'b1, 1'b1, 32'd50);
        tick(12'd4095, 1'b0, 1'b1, 32'd50);        // colour step
        tick(12'd4095, 1'b1, 1'b1, 32'd50);
        tick(12'd4095, 1'b0, 1'b1, 32'd50);        // bounce inside debounce: ignored
        tick(12'd4095, 1'b1, 1'b0, 32'd300);       // horn, confirmed stop, latch
        tick(12'd4095, 1'b1, 1'b1, 32'd50);        // latched: filter path silent
        tick(12'd4095, 1'b1, 1'b0, 32'd250);       // stop again while already latched
        tick(12'd4095, 1'b1, 1'b1, 32'd50);
        // Pot to zero: speed falls through the dead zone (latch clears without
        // a command), then goes negative.
        repeat (4) tick(12'd0, 1'b1, 1'b1, 32'd50);
        tick(12'd0, 1'b0, 1'b0, 32'd300);          // motor, LED, horn and stop together
        repeat (3) tick(12'd0, 1'b1, 1'b1, 32'd50);
        // Timestamp wraps between a press and the next one.
        clock_ms = 32'hFFFF_FF80;
        tick(12'd2048, 1'b0, 1'b1, 32'd0);
        tick(12'd2048, 1'b1, 1'b1, 32'd40);
        tick(12'd2048, 1'b0, 1'b1, 32'h0000_0200);
        tick(12'd2048, 1'b1, 1'b1, 32'd50);
        settle();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                // widest zone edges, no minimum, finest step, no debounce
                0: set_config(12'd1, 12'd4094, 7'd0, 8'd1, 16'd0);
                // inverted zone, minimum above 100, step zero, longest debounce
                1: set_config(12'd4094, 12'd1, 7'd127, 8'd0, 16'd65535);
                // defaults again, run without any idling
                2: set_config(tcwe_pkg::DEAD_LOW_RST, tcwe_pkg::DEAD_HIGH_RST,
                              tcwe_pkg::SPEED_MIN_RST, tcwe_pkg::CHANGE_STEP_RST,
                              tcwe_pkg::DEBOUNCE_MS_RST);
                // one-count upper range, step larger than any change
                3: set_config(12'd1800, 12'd4094, 7'd100, 8'd255, 16'd1);
                default:
                    set_config(12'($urandom_range(1, 4094)), 12'($urandom_range(1, 4094)),
                               7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                               16'($urandom_range(0, 400)));
            endcase
            steady = (ph == 2);
            run_random(RANDOM_PER_PHASE);
            settle();
        end

        if (sb.pending_cmds.size() != 0) begin
            $display("%0t: %0d expected commands never arrived", $time,
                     sb.pending_cmds.size());
            sb.errors++;
        end
        $display("Run covered %0d ticks under %0d register settings, %0d errors.",
                 sb.n_ticks, settings_used, sb.errors);
        $display("Commands seen: %0d motor (%0d zero-speed confirmed), %0d LED, %0d horn.",
                 sb.n_motor, sb.n_confirm, sb.n_led, sb.n_horn);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
